FILE: hdl/gbe_pkg.sv
// Shared types and constants of the gap buffer engine.
package gbe_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CHAR_W   = 8;

	typedef logic [ADDR_W-1:0] ptr_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam ptr_t GAP_END_RST = ptr_t'(CAPACITY - 1);
	localparam ptr_t MAX_LEN     = ptr_t'(CAPACITY - 1);

	typedef enum logic [2:0] {
		CMD_INSERT    = 3'd0,
		CMD_BACKSPACE = 3'd1,
		CMD_MOVE      = 3'd2,
		CMD_READ      = 3'd3,
		CMD_CLEAR     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		char_t wdata;
		logic  re;
		ptr_t  raddr;
	} mem_req_t;

	typedef struct packed {
		char_t   read_char;
		status_t status;
		ptr_t    text_length;
		ptr_t    cursor;
	} result_t;

endpackage

FILE: hdl/gbe_if.sv
// Command and result channel interfaces of the gap buffer engine.
interface gbe_req_if import gbe_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	char_t       char_in;
	ptr_t        position;

	modport source (output valid, output command, output char_in, output position,
		input ready);
	modport sink (input valid, input command, input char_in, input position,
		output ready);
endinterface

interface gbe_rsp_if import gbe_pkg::*; ();
	logic        valid;
	logic        ready;
	char_t       read_char;
	logic [1:0]  status;
	ptr_t        text_length;
	ptr_t        cursor;

	modport source (output valid, output read_char, output status, output text_length,
		output cursor, input ready);
	modport sink (input valid, input read_char, input status, input text_length,
		input cursor, output ready);
endinterface

FILE: hdl/gap_buffer_engine.sv
// Gap buffer engine top level with the result output register.
//
// The engine holds up to 1023 characters of editor text in a 1024-byte single-port-write
// store, with the gap start serving as the cursor. It takes one command word at a time and
// drops ready while a command is in flight. Insert, backspace, clear, unused codes and a
// refused move or read go straight from acceptance to the done state, where the result is
// loaded; an accepted read passes a wait state for the registered store read, and an accepted
// cursor move alternates a store read state and a store write state for each character moved,
// since each character crosses the gap as one store read followed by one store write. Ready
// returns at the edge that loads the result. A new command word is accepted while the previous
// result word still waits on the output register; a finished command holds ready low until
// that register frees. The store needs no initialization after reset.
module gap_buffer_engine import gbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gbe_req_if.sink   req,
	gbe_rsp_if.source rsp
);

	mem_req_t mreq;
	char_t    rdata;
	result_t  res;
	result_t  res_q;
	logic     done;
	logic     out_free;
	logic     rsp_valid_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	gbe_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.done     (done),
		.res      (res),
		.mreq     (mreq),
		.rdata    (rdata)
	);

	gbe_mem u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_char   = res_q.read_char;
	assign rsp.status      = res_q.status;
	assign rsp.text_length = res_q.text_length;
	assign rsp.cursor      = res_q.cursor;

endmodule

FILE: hdl/gbe_mem.sv
// Text store: single write port, one registered read port.
module gbe_mem import gbe_pkg::*; (
	input  logic     clk,
	input  mem_req_t mreq,
	output char_t    rdata
);

	char_t store_q [CAPACITY];
	char_t rdata_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			store_q[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata_q <= store_q[mreq.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/gbe_seq.sv
// Command sequencer holding the gap pointers and stepping cursor moves.
module gbe_seq import gbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gbe_req_if.sink    req,
	input  logic       out_free,
	output logic       done,
	output result_t    res,
	output mem_req_t   mreq,
	input  char_t      rdata
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_MV_RD   = 5'b00010,
		S_MV_WR   = 5'b00100,
		S_RD_WAIT = 5'b01000,
		S_DONE    = 5'b10000
	} state_t;

	state_t  state_q;
	ptr_t    gs_q;
	ptr_t    ge_q;
	ptr_t    pos_q;
	logic    left_q;
	char_t   rd_q;
	status_t st_q;
	ptr_t    len;
	ptr_t    rd_idx;
	cmd_t    cmd;

	assign len    = ptr_t'(GAP_END_RST - ge_q) + gs_q;
	assign cmd    = cmd_t'(req.command);
	assign rd_idx = (req.position < gs_q) ? req.position
		: ptr_t'(ge_q + ptr_t'(1) + (req.position - gs_q));

	assign req.ready = (state_q == S_IDLE);
	assign done      = (state_q == S_DONE);

	assign res.read_char   = rd_q;
	assign res.status      = st_q;
	assign res.text_length = len;
	assign res.cursor      = gs_q;

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_IDLE: begin
				mreq.we    = req.valid && (cmd == CMD_INSERT) && (ge_q != gs_q);
				mreq.waddr = gs_q;
				mreq.wdata = req.char_in;
				mreq.re    = req.valid && (cmd == CMD_READ);
				mreq.raddr = rd_idx;
			end
			S_MV_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = (pos_q < gs_q) ? ptr_t'(gs_q - ptr_t'(1))
					: ptr_t'(ge_q + ptr_t'(1));
			end
			S_MV_WR: begin
				mreq.we    = 1'b1;
				mreq.waddr = left_q ? ge_q : gs_q;
				mreq.wdata = rdata;
			end
			S_RD_WAIT, S_DONE: begin
				mreq = '0;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gs_q    <= '0;
			ge_q    <= GAP_END_RST;
			pos_q   <= '0;
			left_q  <= 1'b0;
			rd_q    <= '0;
			st_q    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						rd_q  <= '0;
						pos_q <= req.position;
						unique case (cmd)
							CMD_INSERT: begin
								state_q <= S_DONE;
								if (ge_q == gs_q) begin
									st_q <= ST_FULL;
								end else begin
									st_q <= ST_OK;
									gs_q <= gs_q + ptr_t'(1);
								end
							end
							CMD_BACKSPACE: begin
								state_q <= S_DONE;
								st_q    <= ST_OK;
								if (gs_q != '0) begin
									gs_q <= gs_q - ptr_t'(1);
								end
							end
							CMD_MOVE: begin
								if (req.position > len) begin
									st_q    <= ST_RANGE;
									state_q <= S_DONE;
								end else begin
									st_q    <= ST_OK;
									state_q <= S_MV_RD;
								end
							end
							CMD_READ: begin
								if (req.position >= len) begin
									st_q    <= ST_RANGE;
									state_q <= S_DONE;
								end else begin
									st_q    <= ST_OK;
									state_q <= S_RD_WAIT;
								end
							end
							CMD_CLEAR: begin
								state_q <= S_DONE;
								st_q    <= ST_OK;
								gs_q    <= '0;
								ge_q    <= GAP_END_RST;
							end
							default: begin
								state_q <= S_DONE;
								st_q    <= ST_OK;
							end
						endcase
					end
				end
				S_MV_RD: begin
					if (pos_q < gs_q) begin
						left_q  <= 1'b1;
						gs_q    <= gs_q - ptr_t'(1);
						state_q <= S_MV_WR;
					end else if (pos_q > gs_q) begin
						left_q  <= 1'b0;
						state_q <= S_MV_WR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MV_WR: begin
					if (left_q) begin
						ge_q <= ge_q - ptr_t'(1);
					end else begin
						gs_q <= gs_q + ptr_t'(1);
						ge_q <= ge_q + ptr_t'(1);
					end
					state_q <= S_MV_RD;
				end
				S_RD_WAIT: begin
					rd_q    <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/gbe_chk.sv
// Port-level assertions of the gap buffer engine and their binding.
module gbe_chk import gbe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input char_t      read_char,
	input logic [1:0] status,
	input ptr_t       text_length,
	input ptr_t       cursor
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor) && $stable(status))
		else $error("Result word dropped or changed while stalled.");

	a_cursor_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cursor <= text_length)
		else $error("Cursor lies beyond the end of the text.");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> text_length <= MAX_LEN)
		else $error("Text length exceeds the usable capacity.");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> text_length == MAX_LEN)
		else $error("Full status reported while the buffer has room.");

	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_char != '0 |-> status == ST_OK)
		else $error("Character returned with a refusal status.");

endmodule

bind gap_buffer_engine gbe_chk u_gbe_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.read_char   (rsp.read_char),
	.status      (rsp.status),
	.text_length (rsp.text_length),
	.cursor      (rsp.cursor)
);
